// File: sv/crfr_pkg.sv
// Package for the CAN frame router: item and result types, opcode and
// target codes, and the built-in receive and transmit routing tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crfr_pkg;

	// default sizes
	localparam int DEF_NUM_CONTROLLERS = 2;
	localparam int DEF_NUM_RX_ENTRIES  = 5;
	localparam int DEF_NUM_TX_ENTRIES  = 3;

	// slots in the front to back queue
	localparam int QUEUE_DEPTH = 2;

	// opcodes
	localparam logic [2:0] OP_RX_FRAME   = 3'd0;
	localparam logic [2:0] OP_TX_REQUEST = 3'd1;
	localparam logic [2:0] OP_TX_CONFIRM = 3'd2;
	localparam logic [2:0] OP_BUS_OFF    = 3'd3;
	localparam logic [2:0] OP_RECOVERED  = 3'd4;
	localparam logic [2:0] OP_ERR_PASS   = 3'd5;
	localparam logic [2:0] OP_ERR_WARN   = 3'd6;
	localparam logic [2:0] OP_SET_MODE   = 3'd7;

	// target layers
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_TP   = 2'd1;
	localparam logic [1:0] TGT_COM  = 2'd2;

	// notifications
	localparam logic [2:0] NTF_NONE     = 3'd0;
	localparam logic [2:0] NTF_BUS_OFF  = 3'd1;
	localparam logic [2:0] NTF_RECOVER  = 3'd2;
	localparam logic [2:0] NTF_PASSIVE  = 3'd3;
	localparam logic [2:0] NTF_WARNING  = 3'd4;

	// status and mode codes
	localparam logic       ST_OK        = 1'b0;
	localparam logic       ST_REJECT    = 1'b1;
	localparam logic [1:0] MODE_ALL_ON  = 2'b11;
	localparam logic [1:0] MODE_OFF     = 2'b00;

	// frame length limits
	localparam logic [6:0] CLASSIC_MAX_LEN = 7'd8;
	localparam logic [6:0] FD_MAX_LEN      = 7'd64;

	// number of built-in table rows
	localparam int RX_BUILTIN = 5;
	localparam int TX_BUILTIN = 3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  controller;
		logic [28:0] can_id;
		logic        id_extended;
		logic        frame_fd;
		logic [6:0]  length;
		logic [7:0]  pdu_id;
		logic [1:0]  new_mode;
	} item_t;

	typedef struct packed {
		logic        status;
		logic [1:0]  target;
		logic [7:0]  pdu_out;
		logic [28:0] tx_can_id;
		logic        tx_handle;
		logic [2:0]  tx_controller;
		logic        tx_id_extended;
		logic        tx_fd;
		logic [6:0]  tx_length;
		logic [2:0]  notify;
		logic [1:0]  mode_now;
		logic [2:0]  error_flags;
	} result_t;

	typedef struct packed {
		logic        used;
		logic [2:0]  ctrl;
		logic [28:0] id;
		logic        ext;
		logic        fd;
		logic [6:0]  min_len;
		logic [6:0]  max_len;
		logic [1:0]  tgt;
	} rx_entry_t;

	typedef struct packed {
		logic        used;
		logic [7:0]  pdu;
		logic        handle;
		logic [2:0]  ctrl;
		logic [28:0] id;
		logic        ext;
		logic        fd;
		logic [6:0]  len;
		logic [1:0]  tgt;
	} tx_entry_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  controller;
		logic [6:0]  length;
		logic [7:0]  pdu_id;
		logic [1:0]  new_mode;
		logic        rx_hit;
		logic [7:0]  rx_pdu;
		logic [1:0]  rx_tgt;
		logic        tx_found;
		logic        tx_static_ok;
		tx_entry_t   tx;
	} cls_t;

	// receive routing table, empty beyond the built-in rows
	function automatic rx_entry_t rx_entry(input int unsigned idx);
		rx_entry_t e;
		e = '0;
		case (idx)
			0: e = '{1'b1, 3'd0, 29'h710, 1'b0, 1'b0, 7'd1, 7'd8,  TGT_TP};
			1: e = '{1'b1, 3'd0, 29'h7DF, 1'b0, 1'b0, 7'd1, 7'd8,  TGT_TP};
			2: e = '{1'b1, 3'd1, 29'h711, 1'b0, 1'b1, 7'd1, 7'd64, TGT_TP};
			3: e = '{1'b1, 3'd1, 29'h7E0, 1'b0, 1'b1, 7'd1, 7'd64, TGT_TP};
			4: e = '{1'b1, 3'd0, 29'h500, 1'b0, 1'b0, 7'd8, 7'd8,  TGT_COM};
			default: e = '0;
		endcase
		return e;
	endfunction

	// transmit routing table, empty beyond the built-in rows
	function automatic tx_entry_t tx_entry(input int unsigned idx);
		tx_entry_t e;
		e = '0;
		case (idx)
			0: e = '{1'b1, 8'd0, 1'b0, 3'd0, 29'h718, 1'b0, 1'b0, 7'd8,  TGT_TP};
			1: e = '{1'b1, 8'd1, 1'b1, 3'd1, 29'h719, 1'b0, 1'b1, 7'd64, TGT_TP};
			2: e = '{1'b1, 8'd2, 1'b0, 3'd0, 29'h500, 1'b0, 1'b0, 7'd8,  TGT_COM};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// File: sv/crfr_if.sv
// Valid/ready channel interfaces for router items and results.
// Depends on crfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface crfr_item_if;
	logic               valid;
	logic               ready;
	crfr_pkg::item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface crfr_result_if;
	logic               valid;
	logic               ready;
	crfr_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/crfr_front.sv
// Front end: accepts item requests and matches them against the routing
// tables, handing a classified item to the queue. Depends on crfr_pkg, crfr_if.
`timescale 1ns / 1ps
`default_nettype none

module crfr_front #(
	parameter int NUM_CONTROLLERS = crfr_pkg::DEF_NUM_CONTROLLERS,
	parameter int NUM_RX_ENTRIES  = crfr_pkg::DEF_NUM_RX_ENTRIES,
	parameter int NUM_TX_ENTRIES  = crfr_pkg::DEF_NUM_TX_ENTRIES
) (
	crfr_item_if.sink        item,
	input  wire logic        q_full,
	output logic             push,
	output crfr_pkg::cls_t   push_cls
);
	import crfr_pkg::*;

	// take a request whenever the queue has room
	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	// first matching receive row
	always_comb begin
		rx_entry_t re;
		tx_entry_t te;
		item_t     it;
		logic      lim_ok;
		it = item.data;
		push_cls = '0;
		push_cls.opcode     = it.opcode;
		push_cls.controller = it.controller;
		push_cls.length     = it.length;
		push_cls.pdu_id     = it.pdu_id;
		push_cls.new_mode   = it.new_mode;
		for (int i = 0; i < NUM_RX_ENTRIES; i++) begin
			re = rx_entry(i);
			if (!push_cls.rx_hit && re.used && re.ctrl == it.controller &&
			    re.id == it.can_id && re.ext == it.id_extended &&
			    re.fd == it.frame_fd && it.length >= re.min_len &&
			    it.length <= re.max_len) begin
				push_cls.rx_hit = 1'b1;
				push_cls.rx_pdu = 8'(i);
				push_cls.rx_tgt = re.tgt;
			end
		end
		// transmit row lookup by pdu number
		for (int j = 0; j < NUM_TX_ENTRIES; j++) begin
			te = tx_entry(j);
			if (!push_cls.tx_found && te.used && te.pdu == it.pdu_id) begin
				push_cls.tx_found = 1'b1;
				push_cls.tx       = te;
			end
		end
		// checks that do not depend on controller state
		lim_ok = push_cls.tx.fd ? (it.length <= FD_MAX_LEN)
		                        : (it.length <= CLASSIC_MAX_LEN);
		push_cls.tx_static_ok = push_cls.tx_found && (it.length != 7'd0) &&
			({1'b0, push_cls.tx.ctrl} < 4'(NUM_CONTROLLERS)) &&
			(it.length == push_cls.tx.len) && lim_ok;
	end

endmodule

`default_nettype wire

// File: sv/crfr_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on crfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crfr_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire crfr_pkg::cls_t   push_cls,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output crfr_pkg::cls_t        head_cls
);
	import crfr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cls_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cls  = slot_q[rd_ptr_q];

	// pointer wrap helper
	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cls;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/crfr_back.sv
// Back end: applies controller mode and error state to classified items,
// updates that state and registers the result. Depends on crfr_pkg, crfr_if.
`timescale 1ns / 1ps
`default_nettype none

module crfr_back #(
	parameter int NUM_CONTROLLERS = crfr_pkg::DEF_NUM_CONTROLLERS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_not_empty,
	input  wire crfr_pkg::cls_t  head_cls,
	output logic                 pop,
	crfr_result_if.source        result
);
	import crfr_pkg::*;

	localparam int CW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

	// per-controller state
	logic [1:0]                 mode_q [NUM_CONTROLLERS];
	logic [NUM_CONTROLLERS-1:0] bus_off_q;
	logic [NUM_CONTROLLERS-1:0] passive_q;
	logic [NUM_CONTROLLERS-1:0] warning_q;
	logic [NUM_CONTROLLERS-1:0] tx_ok_q;

	result_t res_q;
	logic    res_valid_q;

	logic          cok;
	logic [CW-1:0] cidx;
	logic [CW-1:0] tidx;
	logic [1:0]    nmode;
	logic          nbo, npass, nwarn, upd;
	result_t       res;

	assign cok  = ({1'b0, head_cls.controller} < 4'(NUM_CONTROLLERS));
	assign cidx = head_cls.controller[CW-1:0];
	assign tidx = head_cls.tx.ctrl[CW-1:0];

	// take the head when the output register is free or draining
	assign pop = q_not_empty && (!res_valid_q || result.ready);

	// execute one item against controller state
	always_comb begin
		nmode = mode_q[cidx];
		nbo   = bus_off_q[cidx];
		npass = passive_q[cidx];
		nwarn = warning_q[cidx];
		upd   = 1'b0;
		res   = '0;
		res.status = ST_REJECT;
		unique case (head_cls.opcode)
			OP_RX_FRAME: begin
				if (cok && nmode[0] && head_cls.rx_hit) begin
					res.status  = ST_OK;
					res.target  = head_cls.rx_tgt;
					res.pdu_out = head_cls.rx_pdu;
				end
			end
			OP_TX_REQUEST: begin
				if (head_cls.tx_static_ok && tx_ok_q[tidx]) begin
					res.status         = ST_OK;
					res.pdu_out        = head_cls.pdu_id;
					res.tx_can_id      = head_cls.tx.id;
					res.tx_handle      = head_cls.tx.handle;
					res.tx_controller  = head_cls.tx.ctrl;
					res.tx_id_extended = head_cls.tx.ext;
					res.tx_fd          = head_cls.tx.fd;
					res.tx_length      = head_cls.length;
				end
			end
			OP_TX_CONFIRM: begin
				if (head_cls.tx_found) begin
					res.status  = ST_OK;
					res.target  = head_cls.tx.tgt;
					res.pdu_out = head_cls.pdu_id;
				end
			end
			OP_BUS_OFF: begin
				if (cok) begin
					nbo = 1'b1; npass = 1'b0; nwarn = 1'b0;
					nmode = MODE_OFF;
					upd = 1'b1;
					res.status = ST_OK;
					res.notify = NTF_BUS_OFF;
				end
			end
			OP_RECOVERED: begin
				if (cok) begin
					nbo = 1'b0; npass = 1'b0; nwarn = 1'b0;
					nmode = MODE_ALL_ON;
					upd = 1'b1;
					res.status = ST_OK;
					res.notify = NTF_RECOVER;
				end
			end
			OP_ERR_PASS: begin
				if (cok) begin
					npass = 1'b1; nwarn = 1'b0;
					upd = 1'b1;
					res.status = ST_OK;
					res.notify = NTF_PASSIVE;
				end
			end
			OP_ERR_WARN: begin
				if (cok) begin
					// warning is masked while error passive
					if (!npass) begin
						nwarn = 1'b1;
					end
					upd = 1'b1;
					res.status = ST_OK;
					res.notify = NTF_WARNING;
				end
			end
			default: begin
				if (cok) begin
					nmode = head_cls.new_mode;
					upd = 1'b1;
					res.status = ST_OK;
				end
			end
		endcase
		if (cok) begin
			res.mode_now    = nmode;
			res.error_flags = {nwarn, npass, nbo};
		end
	end

	// controller state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CONTROLLERS; k++) begin
				mode_q[k] <= MODE_ALL_ON;
			end
			bus_off_q <= '0;
			passive_q <= '0;
			warning_q <= '0;
			tx_ok_q   <= '1;
		end else if (pop && upd) begin
			mode_q[cidx]    <= nmode;
			bus_off_q[cidx] <= nbo;
			passive_q[cidx] <= npass;
			warning_q[cidx] <= nwarn;
			tx_ok_q[cidx]   <= !nbo && nmode[1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

// File: sv/can_frame_router_with_error_state_core.sv
// Top level of the CAN frame router: front classifier, queue and back end.
// Depends on crfr_pkg, crfr_if, crfr_front, crfr_queue, crfr_back.
//
// channel  dir  payload     handshake
// item     in   item_t      valid/ready, taken when both high
// result   out  result_t    valid/ready, taken when both high
//
// One item per cycle sustained while the result side is ready; an item taken
// is registered in the queue, then its result in the output register.
// Reset brings every controller to mode 3 with all error flags clear, queue
// and output register empty. The queue holds two items, so the input keeps
// taking requests until two wait in it while the result side is stalled.
`timescale 1ns / 1ps
`default_nettype none

module can_frame_router_with_error_state_core #(
	parameter int NUM_CONTROLLERS = crfr_pkg::DEF_NUM_CONTROLLERS,
	parameter int NUM_RX_ENTRIES  = crfr_pkg::DEF_NUM_RX_ENTRIES,
	parameter int NUM_TX_ENTRIES  = crfr_pkg::DEF_NUM_TX_ENTRIES
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	crfr_item_if.sink      item,
	crfr_result_if.source  result
);
	import crfr_pkg::*;

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	cls_t push_cls;
	cls_t head_cls;

	// classify incoming requests
	crfr_front #(
		.NUM_CONTROLLERS (NUM_CONTROLLERS),
		.NUM_RX_ENTRIES  (NUM_RX_ENTRIES),
		.NUM_TX_ENTRIES  (NUM_TX_ENTRIES)
	) u_front (
		.item     (item),
		.q_full   (q_full),
		.push     (push),
		.push_cls (push_cls)
	);

	// decoupling queue
	crfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cls  (push_cls),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_cls  (head_cls)
	);

	// stateful execution and output register
	crfr_back #(
		.NUM_CONTROLLERS (NUM_CONTROLLERS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head_cls    (head_cls),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

// File: verif/crfr_route_monitor.sv
// Watches the item and result channels of the CAN frame router, predicts each
// routing result and compares it with the result the block returns.
// Depends on crfr_pkg and crfr_if.
`timescale 1ns / 1ps

module crfr_route_monitor #(
	parameter int NUM_CONTROLLERS = crfr_pkg::DEF_NUM_CONTROLLERS,
	parameter int NUM_RX_ENTRIES  = crfr_pkg::DEF_NUM_RX_ENTRIES,
	parameter int NUM_TX_ENTRIES  = crfr_pkg::DEF_NUM_TX_ENTRIES
) (
	input  logic    clk,
	input  logic    arst_n,
	crfr_item_if    item_mon,
	crfr_result_if  result_mon,
	output int      fail_count,
	output int      pending
);
	import crfr_pkg::*;

	typedef struct packed {
		logic [2:0]  ctrl;
		logic [28:0] id;
		logic        ext;
		logic        fd;
		logic [6:0]  lo;
		logic [6:0]  hi;
		logic [1:0]  layer;
	} rx_route_t;

	typedef struct packed {
		logic [7:0]  pdu;
		logic        handle;
		logic [2:0]  ctrl;
		logic [28:0] id;
		logic        ext;
		logic        fd;
		logic [6:0]  len;
		logic [1:0]  layer;
	} tx_route_t;

	localparam int RX_SEARCH = (NUM_RX_ENTRIES < RX_BUILTIN) ? NUM_RX_ENTRIES : RX_BUILTIN;
	localparam int TX_SEARCH = (NUM_TX_ENTRIES < TX_BUILTIN) ? NUM_TX_ENTRIES : TX_BUILTIN;

	rx_route_t rx_routes [RX_BUILTIN];
	tx_route_t tx_routes [TX_BUILTIN];

	// per-controller mode and error flags
	logic [1:0] ctrl_mode [8];
	logic       bus_off   [8];
	logic       passive   [8];
	logic       warning   [8];

	result_t routed_due [$];

	// fixed routing tables: controller 0 classic, controller 1 FD
	initial begin
		rx_routes[0] = '{3'd0, 29'h710, 1'b0, 1'b0, 7'd1, 7'd8,  TGT_TP};
		rx_routes[1] = '{3'd0, 29'h7DF, 1'b0, 1'b0, 7'd1, 7'd8,  TGT_TP};
		rx_routes[2] = '{3'd1, 29'h711, 1'b0, 1'b1, 7'd1, 7'd64, TGT_TP};
		rx_routes[3] = '{3'd1, 29'h7E0, 1'b0, 1'b1, 7'd1, 7'd64, TGT_TP};
		rx_routes[4] = '{3'd0, 29'h500, 1'b0, 1'b0, 7'd8, 7'd8,  TGT_COM};
		tx_routes[0] = '{8'd0, 1'b0, 3'd0, 29'h718, 1'b0, 1'b0, 7'd8,  TGT_TP};
		tx_routes[1] = '{8'd1, 1'b1, 3'd1, 29'h719, 1'b0, 1'b1, 7'd64, TGT_TP};
		tx_routes[2] = '{8'd2, 1'b0, 3'd0, 29'h500, 1'b0, 1'b0, 7'd8,  TGT_COM};
	end

	// routing decision for one request, updating controller state on the way
	function automatic result_t route_item(input item_t it);
		result_t   r;
		logic      cok;
		logic      hit;
		int        tx_idx;
		tx_route_t t;
		logic [2:0] c;
		r = '0;
		r.status = ST_REJECT;
		c = it.controller;
		cok = (int'(c) < NUM_CONTROLLERS);
		tx_idx = -1;
		for (int k = 0; k < TX_SEARCH; k++) begin
			if (tx_idx < 0 && tx_routes[k].pdu == it.pdu_id)
				tx_idx = k;
		end
		case (it.opcode)
			OP_RX_FRAME: begin
				hit = 1'b0;
				if (cok && ctrl_mode[c][0]) begin
					for (int k = 0; k < RX_SEARCH; k++) begin
						if (!hit && rx_routes[k].ctrl == c && rx_routes[k].id == it.can_id &&
								rx_routes[k].ext == it.id_extended &&
								rx_routes[k].fd == it.frame_fd &&
								it.length >= rx_routes[k].lo && it.length <= rx_routes[k].hi) begin
							hit = 1'b1;
							r.status = ST_OK;
							r.target = rx_routes[k].layer;
							r.pdu_out = 8'(k);
						end
					end
				end
			end
			OP_TX_REQUEST: begin
				if (it.length != 7'd0 && tx_idx >= 0) begin
					t = tx_routes[tx_idx];
					if (int'(t.ctrl) < NUM_CONTROLLERS && !bus_off[t.ctrl] &&
							ctrl_mode[t.ctrl][1] && it.length == t.len &&
							!(!t.fd && it.length > CLASSIC_MAX_LEN) &&
							!(t.fd && it.length > FD_MAX_LEN)) begin
						r.status = ST_OK;
						r.pdu_out = it.pdu_id;
						r.tx_can_id = t.id;
						r.tx_handle = t.handle;
						r.tx_controller = t.ctrl;
						r.tx_id_extended = t.ext;
						r.tx_fd = t.fd;
						r.tx_length = it.length;
					end
				end
			end
			OP_TX_CONFIRM: begin
				if (tx_idx >= 0) begin
					r.status = ST_OK;
					r.target = tx_routes[tx_idx].layer;
					r.pdu_out = it.pdu_id;
				end
			end
			OP_BUS_OFF: begin
				if (cok) begin
					bus_off[c] = 1'b1;
					passive[c] = 1'b0;
					warning[c] = 1'b0;
					ctrl_mode[c] = MODE_OFF;
					r.status = ST_OK;
					r.notify = NTF_BUS_OFF;
				end
			end
			OP_RECOVERED: begin
				if (cok) begin
					bus_off[c] = 1'b0;
					passive[c] = 1'b0;
					warning[c] = 1'b0;
					ctrl_mode[c] = MODE_ALL_ON;
					r.status = ST_OK;
					r.notify = NTF_RECOVER;
				end
			end
			OP_ERR_PASS: begin
				if (cok) begin
					passive[c] = 1'b1;
					warning[c] = 1'b0;
					r.status = ST_OK;
					r.notify = NTF_PASSIVE;
				end
			end
			OP_ERR_WARN: begin
				if (cok) begin
					// a passive controller keeps its warning flag clear
					if (!passive[c])
						warning[c] = 1'b1;
					r.status = ST_OK;
					r.notify = NTF_WARNING;
				end
			end
			default: begin
				if (cok) begin
					ctrl_mode[c] = it.new_mode;
					r.status = ST_OK;
				end
			end
		endcase
		if (cok) begin
			r.mode_now = ctrl_mode[c];
			r.error_flags = {warning[c], passive[c], bus_off[c]};
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// compare returned results in order, then record new requests
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				ctrl_mode[k] = MODE_ALL_ON;
				bus_off[k] = 1'b0;
				passive[k] = 1'b0;
				warning[k] = 1'b0;
			end
			routed_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				got = result_mon.data;
				if (routed_due.size() == 0) begin
					$error("result 0x%0h arrived with no request waiting", got);
					fail_count++;
				end else begin
					want = routed_due.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("target", 32'(want.target), 32'(got.target));
					check_field("pdu_out", 32'(want.pdu_out), 32'(got.pdu_out));
					check_field("tx_can_id", 32'(want.tx_can_id), 32'(got.tx_can_id));
					check_field("tx_handle", 32'(want.tx_handle), 32'(got.tx_handle));
					check_field("tx_controller", 32'(want.tx_controller),
						32'(got.tx_controller));
					check_field("tx_id_extended", 32'(want.tx_id_extended),
						32'(got.tx_id_extended));
					check_field("tx_fd", 32'(want.tx_fd), 32'(got.tx_fd));
					check_field("tx_length", 32'(want.tx_length), 32'(got.tx_length));
					check_field("notify", 32'(want.notify), 32'(got.notify));
					check_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
					check_field("error_flags", 32'(want.error_flags), 32'(got.error_flags));
				end
			end
			if (item_mon.valid && item_mon.ready)
				routed_due.push_back(route_item(item_mon.data));
			pending = routed_due.size();
		end
	end

endmodule

// File: verif/tb.sv
// Top of the CAN frame router regression: clock, reset, request and result
// drivers with random idling, watchdog and verdict.
// Depends on crfr_pkg, crfr_if, the router core and crfr_route_monitor.
`timescale 1ns / 1ps

module tb;
	import crfr_pkg::*;

	localparam int RANDOM_REQUESTS = 450;
	localparam int IDLE_LIMIT      = 1000;
	localparam int HOLD_AT         = 700;
	localparam int HOLD_CYCLES     = 120;
	localparam int DRAIN_CYCLES    = 8;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;

	crfr_item_if   item_ch ();
	crfr_result_if result_ch ();

	can_frame_router_with_error_state_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	crfr_route_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.result_mon (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic item_t make_item(input logic [2:0] op, input logic [2:0] c,
			input logic [28:0] id, input logic ext, input logic fd, input logic [6:0] len,
			input logic [7:0] pdu, input logic [1:0] nm);
		item_t it;
		it = '{op, c, id, ext, fd, len, pdu, nm};
		return it;
	endfunction

	// random request, mostly well formed against the routing tables
	function automatic item_t random_request();
		item_t     it;
		rx_entry_t re;
		tx_entry_t te;
		int        sel;
		sel = $urandom_range(0, 99);
		it.controller = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 1))
			: 3'($urandom_range(0, 7));
		it.can_id = 29'($urandom());
		it.id_extended = 1'($urandom());
		it.frame_fd = 1'($urandom());
		it.length = 7'($urandom_range(0, 64));
		it.pdu_id = 8'($urandom_range(0, 255));
		it.new_mode = 2'($urandom());
		if (sel < 35) begin
			it.opcode = OP_RX_FRAME;
			if ($urandom_range(0, 99) < 75) begin
				re = rx_entry($urandom_range(0, RX_BUILTIN - 1));
				it.controller = re.ctrl;
				it.can_id = re.id;
				it.id_extended = re.ext;
				it.frame_fd = re.fd;
				it.length = 7'($urandom_range(re.min_len, re.max_len));
				// a few near misses
				case ($urandom_range(0, 7))
					0: it.length = 7'($urandom_range(0, 64));
					1: it.id_extended = ~it.id_extended;
					2: it.frame_fd = ~it.frame_fd;
					default: ;
				endcase
			end
		end else if (sel < 60) begin
			it.opcode = OP_TX_REQUEST;
			if ($urandom_range(0, 99) < 80) begin
				te = tx_entry($urandom_range(0, TX_BUILTIN - 1));
				it.pdu_id = te.pdu;
				it.length = te.len;
			end else if ($urandom_range(0, 1) == 0) begin
				it.pdu_id = 8'($urandom_range(0, 3));
			end
		end else if (sel < 70) begin
			it.opcode = OP_TX_CONFIRM;
			if ($urandom_range(0, 99) < 80)
				it.pdu_id = 8'($urandom_range(0, 3));
		end else if (sel < 75) begin
			it.opcode = OP_BUS_OFF;
		end else if (sel < 85) begin
			it.opcode = OP_RECOVERED;
		end else if (sel < 90) begin
			it.opcode = OP_ERR_PASS;
		end else if (sel < 95) begin
			it.opcode = OP_ERR_WARN;
		end else begin
			it.opcode = OP_SET_MODE;
		end
		return it;
	endfunction

	function automatic int pick_gap(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// entered and left at a falling edge
	task automatic drive_request(input item_t it, input int gap);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
	endtask

	// result side stalls, with one long hold-off while requests keep coming
	initial begin
		int  ready_cycles;
		int  run;
		int  r;
		bit  held;
		ready_cycles = 0;
		held = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && ready_cycles >= HOLD_AT) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				run = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					result_ch.ready <= 1'b1;
					run = $urandom_range(1, 25);
				end else if (r < 88) begin
					result_ch.ready <= 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					result_ch.ready <= 1'b0;
					run = $urandom_range(8, 30);
				end
			end
			repeat (run) @(negedge clk);
			ready_cycles += run;
		end
	end

	// watchdog on cycles with no handshake on either channel
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("can_frame_router_with_error_state_core regression: fail");
		$finish;
	end

	// request stream: directed cases, then random traffic
	initial begin
		item_t directed [$];
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// receive hits on table rows 0, 1, 2 and 4 and the main ways to miss
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h710, 1'b0, 1'b0, 7'd1, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h7DF, 1'b0, 1'b0, 7'd8, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd1, 29'h711, 1'b0, 1'b1, 7'd64, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h500, 1'b0, 1'b0, 7'd8, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h500, 1'b0, 1'b0, 7'd7, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h710, 1'b1, 1'b0, 7'd4, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RX_FRAME, 3'd7, 29'h1FFFFFFF, 1'b1, 1'b1, 7'd64,
			8'd255, 2'd3));
		// transmit requests, good and rejected
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd8, 8'd0, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd64, 8'd1, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd8, 8'd2, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd8, 8'd255, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd7, 8'd0, 2'd0));
		directed.push_back(make_item(OP_TX_CONFIRM, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd2, 2'd0));
		directed.push_back(make_item(OP_TX_CONFIRM, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd255, 2'd0));
		// bus off blocks transmit until recovery
		directed.push_back(make_item(OP_BUS_OFF, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd8, 8'd0, 2'd0));
		directed.push_back(make_item(OP_RECOVERED, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		// warning is suppressed while passive
		directed.push_back(make_item(OP_ERR_PASS, 3'd1, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		directed.push_back(make_item(OP_ERR_WARN, 3'd1, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		directed.push_back(make_item(OP_ERR_WARN, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		// mode off rejects both directions
		directed.push_back(make_item(OP_SET_MODE, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, MODE_OFF));
		directed.push_back(make_item(OP_RX_FRAME, 3'd0, 29'h710, 1'b0, 1'b0, 7'd4, 8'd0, 2'd0));
		directed.push_back(make_item(OP_TX_REQUEST, 3'd0, 29'h0, 1'b0, 1'b0, 7'd8, 8'd2, 2'd0));
		directed.push_back(make_item(OP_SET_MODE, 3'd0, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0,
			MODE_ALL_ON));
		// events and mode on a controller out of range
		directed.push_back(make_item(OP_BUS_OFF, 3'd7, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd0));
		directed.push_back(make_item(OP_SET_MODE, 3'd2, 29'h0, 1'b0, 1'b0, 7'd0, 8'd0, 2'd1));

		foreach (directed[k])
			drive_request(directed[k], pick_gap(1'b0));

		// stretches of back-to-back requests alternate with idling ones
		for (int n = 0; n < RANDOM_REQUESTS; n++)
			drive_request(random_request(), pick_gap(((n / 40) % 3) == 1));
		item_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("can_frame_router_with_error_state_core regression: pass");
		else
			$display("can_frame_router_with_error_state_core regression: fail");
		$finish;
	end

endmodule
